FILE: rtl/ubx_pkg.sv
// Shared types and constants for the UBX frame builder.
`default_nettype none

package ubx_pkg;

    // Sync characters that open every frame
    localparam logic [7:0] SYNC_ONE = 8'hB5;
    localparam logic [7:0] SYNC_TWO = 8'h62;

    // Input item kinds (carried on tuser)
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    localparam int IN_DATA_W  = 40;  // class, id, length, payload byte
    localparam int OUT_DATA_W = 8;

    // One input item as held in the input register
    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [15:0] payload_length;
        logic [7:0]  msg_id;
        logic [7:0]  msg_class;
    } t_item;

    // One result item headed for the output register
    typedef struct packed {
        logic       frame_end;
        logic       run_last;
        logic [7:0] frame_byte;
    } t_result;

    // Emit sequencer; ST_FIRST also serves payload items
    typedef enum logic [7:0] {
        ST_FIRST  = 8'b0000_0001,
        ST_SYNC2  = 8'b0000_0010,
        ST_CLASS  = 8'b0000_0100,
        ST_ID     = 8'b0000_1000,
        ST_LEN_LO = 8'b0001_0000,
        ST_LEN_HI = 8'b0010_0000,
        ST_CK_A   = 8'b0100_0000,
        ST_CK_B   = 8'b1000_0000
    } t_step;

endpackage

`default_nettype wire

FILE: rtl/ubx_in_reg.sv
// Input holding register: takes one item per cycle while empty or being popped, releases it on pop.
`default_nettype none

module ubx_in_reg (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  ubx_pkg::t_item   i_item,
    output logic             o_item_valid,
    output ubx_pkg::t_item   o_item,
    input  wire              i_pop
);
    import ubx_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready      = !r_valid || i_pop;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ubx_seq.sv
// Frame sequencer: header/payload/checksum emission and Fletcher state.
`default_nettype none

module ubx_seq (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_item_valid,
    input  ubx_pkg::t_item    i_item,
    input  wire               i_out_ready,
    output logic              o_res_valid,
    output ubx_pkg::t_result  o_res,
    output logic              o_pop
);
    import ubx_pkg::*;

    t_step       r_step,       n_step;
    logic [7:0]  r_sum_a,      n_sum_a;
    logic [7:0]  r_sum_b,      n_sum_b;
    logic [15:0] r_bytes_left, n_bytes_left;
    logic        r_frame_open, n_frame_open;

    logic        fold_en;
    logic [7:0]  fold_byte;
    logic [7:0]  fold_a;
    logic [7:0]  fold_b;
    logic        pay_last;

    // single shared Fletcher fold
    assign fold_a   = r_sum_a + fold_byte;
    assign fold_b   = r_sum_b + fold_a;
    assign pay_last = (r_bytes_left == 16'd1);

    always_comb begin
        n_step       = r_step;
        n_sum_a      = r_sum_a;
        n_sum_b      = r_sum_b;
        n_bytes_left = r_bytes_left;
        n_frame_open = r_frame_open;
        fold_en      = 1'b0;
        fold_byte    = i_item.payload_byte;
        o_res_valid  = 1'b0;
        o_res        = '0;
        o_pop        = 1'b0;

        if (i_item_valid) begin
            unique case (r_step)
                ST_FIRST: begin
                    if (i_item.kind == KIND_START) begin
                        if (i_out_ready) begin
                            o_res_valid      = 1'b1;
                            o_res.frame_byte = SYNC_ONE;
                            n_sum_a          = '0;
                            n_sum_b          = '0;
                            n_step           = ST_SYNC2;
                        end
                    end else if (!r_frame_open) begin
                        // stray payload byte: dropped silently
                        o_pop = 1'b1;
                    end else if (i_out_ready) begin
                        fold_en          = 1'b1;
                        o_res_valid      = 1'b1;
                        o_res.frame_byte = i_item.payload_byte;
                        n_bytes_left     = r_bytes_left - 16'd1;
                        if (pay_last) begin
                            n_step = ST_CK_A;
                        end else begin
                            o_res.run_last = 1'b1;
                            o_pop          = 1'b1;
                        end
                    end
                end
                ST_SYNC2: begin
                    if (i_out_ready) begin
                        o_res_valid      = 1'b1;
                        o_res.frame_byte = SYNC_TWO;
                        n_step           = ST_CLASS;
                    end
                end
                ST_CLASS: begin
                    fold_byte = i_item.msg_class;
                    if (i_out_ready) begin
                        fold_en          = 1'b1;
                        o_res_valid      = 1'b1;
                        o_res.frame_byte = i_item.msg_class;
                        n_step           = ST_ID;
                    end
                end
                ST_ID: begin
                    fold_byte = i_item.msg_id;
                    if (i_out_ready) begin
                        fold_en          = 1'b1;
                        o_res_valid      = 1'b1;
                        o_res.frame_byte = i_item.msg_id;
                        n_step           = ST_LEN_LO;
                    end
                end
                ST_LEN_LO: begin
                    fold_byte = i_item.payload_length[7:0];
                    if (i_out_ready) begin
                        fold_en          = 1'b1;
                        o_res_valid      = 1'b1;
                        o_res.frame_byte = i_item.payload_length[7:0];
                        n_step           = ST_LEN_HI;
                    end
                end
                ST_LEN_HI: begin
                    fold_byte = i_item.payload_length[15:8];
                    if (i_out_ready) begin
                        fold_en          = 1'b1;
                        o_res_valid      = 1'b1;
                        o_res.frame_byte = i_item.payload_length[15:8];
                        if (i_item.payload_length == '0) begin
                            n_step = ST_CK_A;
                        end else begin
                            o_res.run_last = 1'b1;
                            o_pop          = 1'b1;
                            n_frame_open   = 1'b1;
                            n_bytes_left   = i_item.payload_length;
                            n_step         = ST_FIRST;
                        end
                    end
                end
                ST_CK_A: begin
                    if (i_out_ready) begin
                        o_res_valid      = 1'b1;
                        o_res.frame_byte = r_sum_a;
                        n_step           = ST_CK_B;
                    end
                end
                ST_CK_B: begin
                    if (i_out_ready) begin
                        o_res_valid      = 1'b1;
                        o_res.frame_byte = r_sum_b;
                        o_res.frame_end  = 1'b1;
                        o_res.run_last   = 1'b1;
                        o_pop            = 1'b1;
                        n_frame_open     = 1'b0;
                        n_bytes_left     = '0;
                        n_step           = ST_FIRST;
                    end
                end
                default: begin
                    n_step = ST_FIRST;
                end
            endcase
        end

        if (fold_en) begin
            n_sum_a = fold_a;
            n_sum_b = fold_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= ST_FIRST;
            r_sum_a      <= '0;
            r_sum_b      <= '0;
            r_bytes_left <= '0;
            r_frame_open <= 1'b0;
        end else begin
            r_step       <= n_step;
            r_sum_a      <= n_sum_a;
            r_sum_b      <= n_sum_b;
            r_bytes_left <= n_bytes_left;
            r_frame_open <= n_frame_open;
        end
    end

    // between items, an open frame always expects at least one more payload byte
    a_open_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frame_open && (r_step == ST_FIRST)) |-> (r_bytes_left != 16'd0))
        else $error("frame open with no bytes left");

    // a result is only produced when the output register can take it
    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_out_ready)
        else $error("result emitted without output room");

    // releasing an item returns the sequencer to its first step
    a_pop_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_step == ST_FIRST))
        else $error("sequencer not rewound after pop");

    // mid-item steps only occur while that item is still held
    a_step_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != ST_FIRST) |-> i_item_valid)
        else $error("sequencer mid-item with no item held");

endmodule

`default_nettype wire

FILE: rtl/ubx_out_reg.sv
// Output register stage for the result stream.
`default_nettype none

module ubx_out_reg (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  ubx_pkg::t_result  i_res,
    output logic              o_ready,
    output logic              o_valid,
    output ubx_pkg::t_result  o_res,
    input  wire               i_ready
);
    import ubx_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ubx_frame_builder.sv
// Top level of the UBX command frame builder.
//
// Input stream (s_axis): tuser is the item kind, 0 = start frame, 1 = payload
// byte. tdata carries class [7:0], id [15:8], payload length [31:16] and
// payload byte [39:32]; only the fields of the item's kind are used.
// Output stream (m_axis): one frame byte per transaction in tdata, tlast on the
// checksum B byte that ends a frame, tuser on the last byte caused by one input.
//
// A start item yields six header bytes (B5 62 class id len_lo len_hi), plus the
// two checksum bytes at once when the length is zero. Each payload byte yields
// itself, plus checksum A/B after the last one. Payload bytes with no frame open
// are dropped; a new start abandons an open frame without a checksum.
//
// Flow: the first result passes the input register and then the output register
// before it is valid on m_axis. The sequencer emits one byte per cycle while the
// output register can take it, so payload items stream at one per cycle likewise;
// a start item is held until its last header or checksum byte is out, a closing
// payload byte until checksum B. Reset clears the sums, the open-frame flag and
// both register stages. When the receiver stalls the output register holds, the
// sequencer waits, and the input register fills and drops s_axis_tready.
`default_nettype none

module ubx_frame_builder (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,   // msg_class, msg_id, payload_length, payload_byte
    input  wire         s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // frame_byte
    output logic        m_axis_tlast,   // frame_end
    output logic        m_axis_tuser    // run_last
);
    import ubx_pkg::*;

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    pop;
    t_result seq_res;
    logic    seq_res_valid;
    logic    out_ready;
    t_result out_res;

    always_comb begin
        in_item.kind           = s_axis_tuser;
        in_item.msg_class      = s_axis_tdata[7:0];
        in_item.msg_id         = s_axis_tdata[15:8];
        in_item.payload_length = s_axis_tdata[31:16];
        in_item.payload_byte   = s_axis_tdata[IN_DATA_W-1:32];
    end

    ubx_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_item       (in_item),
        .o_item_valid (held_valid),
        .o_item       (held_item),
        .i_pop        (pop)
    );

    ubx_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (held_valid),
        .i_item       (held_item),
        .i_out_ready  (out_ready),
        .o_res_valid  (seq_res_valid),
        .o_res        (seq_res),
        .o_pop        (pop)
    );

    ubx_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (seq_res_valid),
        .i_res   (seq_res),
        .o_ready (out_ready),
        .o_valid (m_axis_tvalid),
        .o_res   (out_res),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = out_res.frame_byte[OUT_DATA_W-1:0];
    assign m_axis_tlast = out_res.frame_end;
    assign m_axis_tuser = out_res.run_last;

endmodule

`default_nettype wire
